### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk; they are compiled out when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define ABM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included
`define ABM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ABM_ASSERT(lbl, prop, msg)
`define ABM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### src/abm_pkg.sv
// ----------------------------------------------------------------------------
// abm_pkg
// Shared types and constants of the branch and move-wide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package abm_pkg;

  // Data path and register file geometry
  localparam int XLEN      = 64;
  localparam int REG_COUNT = 31;
  localparam int RF_DEPTH  = REG_COUNT + 1;
  localparam int RF_AW     = $clog2(RF_DEPTH);

  // Fixed register indexes
  localparam logic [RF_AW-1:0] LINK_REG = RF_AW'(30);
  localparam logic [RF_AW-1:0] SP_INDEX = RF_AW'(31);

  // Stream widths
  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 72;

  // Page mask for adrp and lane mask for move-wide
  localparam logic [XLEN-1:0] PAGE_MASK = 64'h0000_0000_0000_0fff;
  localparam logic [XLEN-1:0] LANE_MASK = 64'h0000_0000_0000_ffff;

  typedef enum logic [3:0] {
    ACT_NOP      = 4'd0,
    ACT_EXIT     = 4'd1,
    ACT_SVC      = 4'd2,
    ACT_BRK      = 4'd3,
    ACT_RET      = 4'd4,
    ACT_BRANCH   = 4'd5,
    ACT_BCOND    = 4'd6,
    ACT_CBZ      = 4'd7,
    ACT_TBZ      = 4'd8,
    ACT_ADR      = 4'd9,
    ACT_ADRP     = 4'd10,
    ACT_MOVWIDE  = 4'd11,
    ACT_SETFLAGS = 4'd12
  } action_t;

  typedef enum logic [1:0] {
    ST_CONTINUE = 2'd0,
    ST_END      = 2'd1,
    ST_TRAP     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    TRAP_NONE = 2'd0,
    TRAP_SVC  = 2'd1,
    TRAP_BRK  = 2'd2
  } trap_t;

  typedef enum logic [1:0] {
    MOV_N    = 2'd0,
    MOV_KEEP = 2'd1,
    MOV_Z    = 2'd2,
    MOV_K    = 2'd3
  } move_t;

  // Register file read request
  typedef struct packed {
    logic             en;
    logic [RF_AW-1:0] addr;
  } rf_rd_t;

  // Register file write request
  typedef struct packed {
    logic             en;
    logic [RF_AW-1:0] addr;
    logic [XLEN-1:0]  data;
  } rf_wr_t;

endpackage

`default_nettype wire

### src/arm64_branch_and_move_unit.sv
// ----------------------------------------------------------------------------
// arm64_branch_and_move_unit
// Executes pre-decoded AArch64 branch, adr/adrp and move-wide operations
// against a register file, stack pointer, program counter and NZCV flags.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ stream carries one decoded operation per transaction; the out_
//   stream returns exactly one result per operation: status, trap kind and
//   the program counter after the operation, in order.
//   Each operation is registered into the execute stage along with its
//   register file read, then executed into the output register.
//   Throughput: one operation per cycle while out_tready is high. The register
//   file memory has one read and one write port; a write on the same edge as
//   the next read is bypassed, so dependent operations still issue back to back.
//   Reset clears pc, flags, all registers (via per-entry valid bits) and the
//   pipeline; the block is ready in the first cycle after reset.
//   When the receiver holds out_tready low, the result is held in the output
//   register, one more operation waits in the execute stage, and in_tready
//   drops only once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module arm64_branch_and_move_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // action[3:0], reg_index[8:4], cond_code[12:9], width_64[13], sense[14],
  // bit_index[20:15], half_select[22:21], move_kind[24:23], imm16[40:25],
  // offset[72:41], target_value[136:73], zero fill[143:137]
  input  wire logic [abm_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // status[1:0], trap_kind[3:2], next_pc[67:4], zero fill[71:68]
  output logic [abm_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready
);
  import abm_pkg::*;

  // Execute stage payload
  logic             s1_vld_r;
  action_t          s1_action_r;
  logic [RF_AW-1:0] s1_reg_r;
  logic [3:0]       s1_cond_r;
  logic             s1_wide_r;
  logic             s1_sense_r;
  logic [5:0]       s1_bit_r;
  logic [1:0]       s1_half_r;
  move_t            s1_kind_r;
  logic [15:0]      s1_imm_r;
  logic [31:0]      s1_off_r;
  logic [XLEN-1:0]  s1_target_r;

  // Architectural state outside the register file
  logic [XLEN-1:0]  pc_r, pc_nxt;
  logic [3:0]       flags_r, flags_nxt;

  // Output register
  logic             out_vld_r;
  status_t          out_status_r, status_nxt;
  trap_t            out_trap_r, trap_nxt;
  logic [XLEN-1:0]  out_pc_r;

  logic             in_acc;
  logic             adv;
  rf_rd_t           rf_rd;
  rf_wr_t           rf_wr;
  logic [XLEN-1:0]  rs_val;

  // Execute helpers
  logic [XLEN-1:0]  off_sx;
  logic [XLEN-1:0]  seq_pc;
  logic [XLEN-1:0]  tgt_pc;
  logic [XLEN-1:0]  lane;
  logic [XLEN-1:0]  lane_mask;
  logic [5:0]       lane_sh;
  logic             cond_ok;
  logic             cond_raw;
  logic             taken;
  logic [XLEN-1:0]  cbz_val;

  // Handshake: advance when the output register is free or draining
  assign adv       = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // Issue the register read with the transaction
  assign rf_rd.en   = in_acc;
  assign rf_rd.addr = in_tdata[8:4];

  abm_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd      (rf_rd),
    .wr      (rf_wr),
    .rd_data (rs_val)
  );

  // Execute stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  // Capture operation fields
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= action_t'(in_tdata[3:0]);
      s1_reg_r    <= in_tdata[8:4];
      s1_cond_r   <= in_tdata[12:9];
      s1_wide_r   <= in_tdata[13];
      s1_sense_r  <= in_tdata[14];
      s1_bit_r    <= in_tdata[20:15];
      s1_half_r   <= in_tdata[22:21];
      s1_kind_r   <= move_t'(in_tdata[24:23]);
      s1_imm_r    <= in_tdata[40:25];
      s1_off_r    <= in_tdata[72:41];
      s1_target_r <= in_tdata[136:73];
    end
  end

  // Common address terms
  assign off_sx    = {{(XLEN-32){s1_off_r[31]}}, s1_off_r};
  assign seq_pc    = pc_r + XLEN'(4);
  assign tgt_pc    = pc_r + off_sx;
  assign lane_sh   = {s1_half_r, 4'b0000};
  assign lane      = XLEN'(s1_imm_r) << lane_sh;
  assign lane_mask = LANE_MASK << lane_sh;
  assign cbz_val   = s1_wide_r ? rs_val : {32'b0, rs_val[31:0]};

  // Evaluate condition code against NZCV
  always_comb begin
    case (s1_cond_r[3:1])
      3'd0:    cond_raw = flags_r[2];
      3'd1:    cond_raw = flags_r[1];
      3'd2:    cond_raw = flags_r[3];
      3'd3:    cond_raw = flags_r[0];
      3'd4:    cond_raw = flags_r[1] && !flags_r[2];
      3'd5:    cond_raw = (flags_r[3] == flags_r[0]);
      3'd6:    cond_raw = !flags_r[2] && (flags_r[3] == flags_r[0]);
      default: cond_raw = 1'b1;
    endcase
    if (s1_cond_r[3:1] == 3'd7) begin
      cond_ok = 1'b1;
    end else begin
      cond_ok = s1_cond_r[0] ? !cond_raw : cond_raw;
    end
  end

  // Execute: next pc, flags, status and register write
  always_comb begin
    pc_nxt     = seq_pc;
    flags_nxt  = flags_r;
    status_nxt = ST_CONTINUE;
    trap_nxt   = TRAP_NONE;
    taken      = 1'b0;
    rf_wr.en   = 1'b0;
    rf_wr.addr = s1_reg_r;
    rf_wr.data = tgt_pc;
    case (s1_action_r)
      ACT_EXIT: begin
        pc_nxt     = s1_target_r;
        status_nxt = ST_END;
      end
      ACT_SVC: begin
        status_nxt = ST_TRAP;
        trap_nxt   = TRAP_SVC;
      end
      ACT_BRK: begin
        status_nxt = ST_TRAP;
        trap_nxt   = TRAP_BRK;
      end
      ACT_RET: begin
        pc_nxt     = rs_val;
        status_nxt = ST_END;
      end
      ACT_BRANCH: begin
        rf_wr.en   = s1_sense_r;
        rf_wr.addr = LINK_REG;
        rf_wr.data = seq_pc;
        pc_nxt     = tgt_pc;
        status_nxt = ST_END;
      end
      ACT_BCOND, ACT_CBZ, ACT_TBZ: begin
        if (s1_action_r == ACT_BCOND) begin
          taken = cond_ok;
        end else if (s1_action_r == ACT_CBZ) begin
          taken = ((cbz_val == '0) == !s1_sense_r);
        end else begin
          taken = (rs_val[s1_bit_r] == s1_sense_r);
        end
        pc_nxt     = taken ? tgt_pc : seq_pc;
        status_nxt = (taken && (tgt_pc != seq_pc)) ? ST_END : ST_CONTINUE;
      end
      ACT_ADR: begin
        rf_wr.en = 1'b1;
      end
      ACT_ADRP: begin
        rf_wr.en   = 1'b1;
        rf_wr.data = (pc_r & ~PAGE_MASK) + (off_sx << 12);
      end
      ACT_MOVWIDE: begin
        rf_wr.en = 1'b1;
        case (s1_kind_r)
          MOV_N:   rf_wr.data = ~lane;
          MOV_Z:   rf_wr.data = lane;
          MOV_K:   rf_wr.data = (rs_val & ~lane_mask) | lane;
          default: rf_wr.data = rs_val;
        endcase
      end
      ACT_SETFLAGS: begin
        flags_nxt = s1_imm_r[3:0];
        pc_nxt    = pc_r;
      end
      default: begin
        pc_nxt = seq_pc;
      end
    endcase
    // Commit only when the stage advances
    rf_wr.en = rf_wr.en && adv;
  end

  // Architectural state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= '0;
      flags_r <= '0;
    end else if (adv) begin
      pc_r    <= pc_nxt;
      flags_r <= flags_nxt;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= status_nxt;
      out_trap_r   <= trap_nxt;
      out_pc_r     <= pc_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0, out_pc_r, out_trap_r, out_status_r};

  // Checks
  `ABM_ASSERT(a_acc_fills_s1, (in_tvalid && in_tready) |=> s1_vld_r, "accepted op lost before execute")
  `ABM_ASSERT(a_trap_match, out_vld_r |-> ((out_trap_r != TRAP_NONE) == (out_status_r == ST_TRAP)), "trap kind and status disagree")
  `ABM_ASSERT(a_out_pc_is_pc, adv |=> (out_pc_r == pc_r), "result pc differs from committed pc")
  `ABM_ASSERT(a_no_write_stalled, (s1_vld_r && !adv) |-> !rf_wr.en, "register write while execute stalled")

endmodule

`default_nettype wire

### src/abm_regfile.sv
// ----------------------------------------------------------------------------
// abm_regfile
// General registers and stack pointer in one synchronous memory with a
// registered read, per-entry valid bits for reset-to-zero, and write-to-read
// bypass for a write landing on the same edge as the read.
// ----------------------------------------------------------------------------
`default_nettype none

module abm_regfile (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire abm_pkg::rf_rd_t            rd,
  input  wire abm_pkg::rf_wr_t            wr,
  output logic [abm_pkg::XLEN-1:0]        rd_data
);
  import abm_pkg::*;

  logic [XLEN-1:0]     mem [RF_DEPTH];
  logic [XLEN-1:0]     q_r;
  logic [RF_DEPTH-1:0] vld_r;
  logic                hit_vld_r;
  logic                byp_r;
  logic [XLEN-1:0]     byp_data_r;

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      q_r <= mem[rd.addr];
    end
  end

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // Capture valid flag and bypass with the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_vld_r <= 1'b0;
      byp_r     <= 1'b0;
    end else if (rd.en) begin
      hit_vld_r <= vld_r[rd.addr];
      byp_r     <= wr.en && (wr.addr == rd.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      byp_data_r <= wr.data;
    end
  end

  // Select bypass, stored value or reset value
  always_comb begin
    if (byp_r) begin
      rd_data = byp_data_r;
    end else if (hit_vld_r) begin
      rd_data = q_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

`default_nettype wire

### tb/sv/arm64_branch_and_move_unit_test.sv
// ----------------------------------------------------------------------------
// arm64_branch_and_move_unit_test
// Self-checking bench for the branch and move-wide unit. A short table of
// directed operations covers field extremes, every action and the corner
// cases (pc wrap, taken-by-four, always-true conditions, unused actions).
// Random operation sequences follow. A local executor tracks registers, sp,
// pc and flags; results are checked in order against it or a row's fixed result.
// ----------------------------------------------------------------------------
`default_nettype none

module arm64_branch_and_move_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import abm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1550;
  localparam int CALM_TAIL      = 150;
  localparam int DRAIN_CYCLES   = 10;

  // Action code with no operation assigned; executes as nop
  localparam logic [3:0] ACT_UNUSED = 4'hf;

  // Condition codes used by name in the directed table
  localparam logic [3:0] COND_EQ = 4'h0;
  localparam logic [3:0] COND_AL = 4'he;
  localparam logic [3:0] COND_NV = 4'hf;

  // Condition groups selected by cond_code[3:1]
  typedef enum logic [2:0] {
    CG_EQ, CG_CS, CG_MI, CG_VS, CG_HI, CG_GE, CG_GT, CG_AL
  } cond_group_t;

  typedef struct {
    logic [3:0]  action;
    logic [4:0]  reg_index;
    logic [3:0]  cond_code;
    logic        width_64;
    logic        sense;
    logic [5:0]  bit_index;
    logic [1:0]  half_select;
    logic [1:0]  move_kind;
    logic [15:0] imm16;
    logic [31:0] offset;
    logic [63:0] target_value;
  } op_t;

  typedef struct {
    status_t     status;
    trap_t       trap_kind;
    logic [63:0] next_pc;
  } res_t;

  typedef struct {
    op_t  op;
    logic fixed;
    res_t want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;

  // Architectural state as the executor sees it
  logic [63:0] gpr_model [0:REG_COUNT-1];
  logic [63:0] sp_model;
  logic [63:0] pc_model;
  logic [3:0]  nzcv_model;

  // Operation on the input bus and its optional typed-in result
  op_t  cur_op;
  logic cur_fixed = 1'b0;
  res_t cur_want;

  res_t pending_results [$];
  row_t directed_rows [$];
  logic in_taken = 1'b0;
  logic calm = 1'b0;
  int   errors = 0;
  int   idle_cycles = 0;
  int   items_sent = 0;
  logic in_idle_on = 1'b1;
  int   in_run_left = 40;

  arm64_branch_and_move_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),   // action, reg_index, cond_code, width_64, sense, bit_index,
                              // half_select, move_kind, imm16, offset, target_value
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),  // status, trap_kind, next_pc
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // Free-running clock
  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [IN_TDATA_W-1:0] pack_op(op_t op);
    return {7'b0, op.target_value, op.offset, op.imm16, op.move_kind, op.half_select,
            op.bit_index, op.sense, op.width_64, op.cond_code, op.reg_index, op.action};
  endfunction

  function automatic logic [63:0] read_reg(logic [4:0] idx);
    if (idx == SP_INDEX) return sp_model;
    return gpr_model[idx];
  endfunction

  function automatic void write_reg(logic [4:0] idx, logic [63:0] value);
    if (idx == SP_INDEX) sp_model = value;
    else gpr_model[idx] = value;
  endfunction

  function automatic logic cond_holds(logic [3:0] code);
    logic n, z, c, v, r;
    n = nzcv_model[3];
    z = nzcv_model[2];
    c = nzcv_model[1];
    v = nzcv_model[0];
    case (cond_group_t'(code[3:1]))
      CG_EQ: r = z;
      CG_CS: r = c;
      CG_MI: r = n;
      CG_VS: r = v;
      CG_HI: r = c && !z;
      CG_GE: r = (n == v);
      CG_GT: r = !z && (n == v);
      default: return 1'b1;
    endcase
    return code[0] ? !r : r;
  endfunction

  // Execute one operation on the local state and return its result
  function automatic res_t execute_op(op_t op);
    res_t        r;
    logic [63:0] pc, seq, off, lane, v;
    int unsigned sh;
    logic        taken;
    pc          = pc_model;
    seq         = pc + 64'd4;
    off         = {{32{op.offset[31]}}, op.offset};
    r.status    = ST_CONTINUE;
    r.trap_kind = TRAP_NONE;
    case (op.action)
      ACT_EXIT: begin
        pc_model = op.target_value;
        r.status = ST_END;
      end
      ACT_SVC, ACT_BRK: begin
        pc_model    = seq;
        r.status    = ST_TRAP;
        r.trap_kind = (op.action == ACT_SVC) ? TRAP_SVC : TRAP_BRK;
      end
      ACT_RET: begin
        pc_model = read_reg(op.reg_index);
        r.status = ST_END;
      end
      ACT_BRANCH: begin
        if (op.sense) write_reg(LINK_REG, seq);
        pc_model = pc + off;
        r.status = ST_END;
      end
      ACT_BCOND, ACT_CBZ, ACT_TBZ: begin
        if (op.action == ACT_BCOND) begin
          taken = cond_holds(op.cond_code);
        end else if (op.action == ACT_CBZ) begin
          v = read_reg(op.reg_index);
          if (!op.width_64) v[63:32] = '0;
          taken = (v == 64'd0) == (op.sense == 1'b0);
        end else begin
          v     = read_reg(op.reg_index);
          taken = (v[op.bit_index] == op.sense);
        end
        pc_model = taken ? pc + off : seq;
        r.status = (pc_model == seq) ? ST_CONTINUE : ST_END;
      end
      ACT_ADR: begin
        write_reg(op.reg_index, pc + off);
        pc_model = seq;
      end
      ACT_ADRP: begin
        write_reg(op.reg_index, (pc & ~PAGE_MASK) + (off << 12));
        pc_model = seq;
      end
      ACT_MOVWIDE: begin
        sh   = 16 * op.half_select;
        lane = {48'b0, op.imm16} << sh;
        case (move_t'(op.move_kind))
          MOV_N:   v = ~lane;
          MOV_Z:   v = lane;
          MOV_K:   v = (read_reg(op.reg_index) & ~(LANE_MASK << sh)) | lane;
          default: v = read_reg(op.reg_index);
        endcase
        write_reg(op.reg_index, v);
        pc_model = seq;
      end
      ACT_SETFLAGS: begin
        nzcv_model = op.imm16[3:0];
      end
      default: begin
        pc_model = seq;
      end
    endcase
    r.next_pc = pc_model;
    return r;
  endfunction

  function automatic op_t op_of(logic [3:0] action, logic [4:0] reg_index,
                                logic [3:0] cond_code, logic width_64, logic sense,
                                logic [5:0] bit_index, logic [1:0] half_select,
                                logic [1:0] move_kind, logic [15:0] imm16,
                                logic [31:0] offset, logic [63:0] target_value);
    op_t op;
    op.action       = action;
    op.reg_index    = reg_index;
    op.cond_code    = cond_code;
    op.width_64     = width_64;
    op.sense        = sense;
    op.bit_index    = bit_index;
    op.half_select  = half_select;
    op.move_kind    = move_kind;
    op.imm16        = imm16;
    op.offset       = offset;
    op.target_value = target_value;
    return op;
  endfunction

  function automatic void add_row(op_t op, logic fixed, status_t status, trap_t trap_kind,
                                  logic [63:0] next_pc);
    row_t row;
    row.op             = op;
    row.fixed          = fixed;
    row.want.status    = status;
    row.want.trap_kind = trap_kind;
    row.want.next_pc   = next_pc;
    directed_rows.push_back(row);
  endfunction

  function automatic op_t rand_op();
    return op_of(4'($urandom_range(0, 15)), 5'($urandom), 4'($urandom), 1'($urandom),
                 1'($urandom), 6'($urandom), 2'($urandom), 2'($urandom), 16'($urandom),
                 $urandom, {$urandom, $urandom});
  endfunction

  // Favor zero, four, the extremes and short branches
  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 7))
      0: return 32'd4;
      1: return 32'd0;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4, 5: return 32'($urandom_range(0, 255) * 4) - 32'd512;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a few hot registers so operations depend on each other
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 1) == 0) return 5'($urandom);
    case ($urandom_range(0, 4))
      0, 1, 2: return 5'($urandom_range(0, 2));
      3: return LINK_REG;
      default: return SP_INDEX;
    endcase
  endfunction

  // Present one operation and hold it until the transaction completes
  task automatic send(op_t op, logic fixed, res_t want);
    int gap;
    gap = 0;
    if (!calm && in_idle_on && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_op(op);
    cur_op    <= op;
    cur_fixed <= fixed;
    cur_want  <= want;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
    items_sent++;
    in_run_left--;
    if (in_run_left <= 0) begin
      in_idle_on  = !in_idle_on;
      in_run_left = $urandom_range(20, 80);
    end
  endtask

  // Well-formed sequences with random content, plus plain noise
  task automatic run_scenario(res_t none);
    op_t        op;
    logic [4:0] r;
    logic [1:0] last_half;
    case ($urandom_range(0, 6))
      0: begin
        op = rand_op();
        op.action = ACT_SETFLAGS;
        send(op, 1'b0, none);
        op = rand_op();
        op.action = ACT_BCOND;
        op.offset = pick_offset();
        send(op, 1'b0, none);
      end
      1: begin
        r = pick_reg();
        last_half = '0;
        repeat ($urandom_range(1, 3)) begin
          op = rand_op();
          op.action    = ACT_MOVWIDE;
          op.reg_index = r;
          if ($urandom_range(0, 2) == 0) op.imm16 = '0;
          send(op, 1'b0, none);
          last_half = op.half_select;
        end
        op = rand_op();
        op.reg_index = r;
        op.offset    = pick_offset();
        if ($urandom_range(0, 1) == 0) begin
          op.action = ACT_CBZ;
        end else begin
          op.action = ACT_TBZ;
          if ($urandom_range(0, 1) == 0) op.bit_index = {last_half, 4'($urandom)};
        end
        send(op, 1'b0, none);
      end
      2: begin
        r = pick_reg();
        op = rand_op();
        op.action    = ($urandom_range(0, 1) == 0) ? ACT_ADR : ACT_ADRP;
        op.reg_index = r;
        op.offset    = pick_offset();
        send(op, 1'b0, none);
        op = rand_op();
        op.action    = ACT_RET;
        op.reg_index = r;
        send(op, 1'b0, none);
      end
      3: begin
        op = rand_op();
        op.action = ACT_BRANCH;
        op.sense  = 1'b1;
        op.offset = pick_offset();
        send(op, 1'b0, none);
        repeat ($urandom_range(0, 2)) send(rand_op(), 1'b0, none);
        op = rand_op();
        op.action    = ACT_RET;
        op.reg_index = LINK_REG;
        send(op, 1'b0, none);
      end
      default: begin
        send(rand_op(), 1'b0, none);
      end
    endcase
  endtask

  // Stimulus: reset, directed table, random sequences, drain
  initial begin : stimulus
    res_t none;
    int   total;
    none.status    = ST_CONTINUE;
    none.trap_kind = TRAP_NONE;
    none.next_pc   = '0;
    cur_want       = none;
    cur_op         = op_of(ACT_NOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < REG_COUNT; i++) gpr_model[i] = '0;
    sp_model   = '0;
    pc_model   = '0;
    nzcv_model = '0;

    // action, reg, cond, wide, sense, bit, half, kind, imm16, offset, target
    add_row(op_of(ACT_NOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_CONTINUE, TRAP_NONE, 64'd4);
    add_row(op_of(ACT_SVC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_TRAP, TRAP_SVC, 64'd8);
    add_row(op_of(ACT_BRK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_TRAP, TRAP_BRK, 64'd12);
    add_row(op_of(ACT_EXIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, '1), 1, ST_END, TRAP_NONE, '1);
    // pc wraps past the top of the address space
    add_row(op_of(ACT_SVC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_TRAP, TRAP_SVC, 64'd3);
    add_row(op_of(ACT_UNUSED, '1, '1, 1, 1, '1, '1, '1, '1, '1, '1), 1, ST_CONTINUE,
            TRAP_NONE, 64'd7);
    add_row(op_of(ACT_EXIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_END, TRAP_NONE, 64'd0);
    add_row(op_of(ACT_SETFLAGS, 0, 0, 0, 0, 0, 0, 0, '1, 0, 0), 1, ST_CONTINUE, TRAP_NONE,
            64'd0);
    add_row(op_of(ACT_BCOND, 0, COND_NV, 0, 0, 0, 0, 0, 0, 32'h7fff_fffc, 0), 0,
            ST_CONTINUE, TRAP_NONE, 0);
    add_row(op_of(ACT_BCOND, 0, COND_EQ, 0, 0, 0, 0, 0, 0, -32'sd8, 0), 0, ST_CONTINUE,
            TRAP_NONE, 0);
    add_row(op_of(ACT_SETFLAGS, 0, 0, 0, 0, 0, 0, 0, 16'hfff0, 0, 0), 0, ST_CONTINUE,
            TRAP_NONE, 0);
    // taken branch by four continues
    add_row(op_of(ACT_BCOND, 0, COND_AL, 0, 0, 0, 0, 0, 0, 32'd4, 0), 0, ST_CONTINUE,
            TRAP_NONE, 0);
    add_row(op_of(ACT_MOVWIDE, 0, 0, 0, 0, 0, 3, MOV_Z, '1, 0, 0), 0, ST_CONTINUE,
            TRAP_NONE, 0);
    add_row(op_of(ACT_CBZ, 0, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 0), 0, ST_CONTINUE,
            TRAP_NONE, 0);
    add_row(op_of(ACT_CBZ, 0, 0, 1, 0, 0, 0, 0, 0, 32'd64, 0), 0, ST_CONTINUE, TRAP_NONE, 0);
    add_row(op_of(ACT_MOVWIDE, 0, 0, 0, 0, 0, 0, MOV_K, 16'h1234, 0, 0), 0, ST_CONTINUE,
            TRAP_NONE, 0);
    add_row(op_of(ACT_MOVWIDE, 0, 0, 0, 0, 0, 0, MOV_KEEP, '1, 0, 0), 0, ST_CONTINUE,
            TRAP_NONE, 0);
    add_row(op_of(ACT_MOVWIDE, SP_INDEX, 0, 0, 0, 0, 2, MOV_N, 0, 0, 0), 0, ST_CONTINUE,
            TRAP_NONE, 0);
    add_row(op_of(ACT_TBZ, SP_INDEX, 0, 0, 1, 63, 0, 0, 0, 32'd16, 0), 0, ST_CONTINUE,
            TRAP_NONE, 0);
    add_row(op_of(ACT_TBZ, SP_INDEX, 0, 0, 0, 32, 0, 0, 0, -32'sd4, 0), 0, ST_CONTINUE,
            TRAP_NONE, 0);
    add_row(op_of(ACT_ADR, 5, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 0), 0, ST_CONTINUE,
            TRAP_NONE, 0);
    add_row(op_of(ACT_ADRP, SP_INDEX, 0, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff, 0), 0,
            ST_CONTINUE, TRAP_NONE, 0);
    add_row(op_of(ACT_BRANCH, 0, 0, 0, 1, 0, 0, 0, 0, 32'h100, 0), 0, ST_CONTINUE,
            TRAP_NONE, 0);
    add_row(op_of(ACT_RET, LINK_REG, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, ST_CONTINUE,
            TRAP_NONE, 0);
    add_row(op_of(ACT_RET, SP_INDEX, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, ST_CONTINUE,
            TRAP_NONE, 0);

    // Hold reset, then release it
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    foreach (directed_rows[i]) send(directed_rows[i].op, directed_rows[i].fixed,
                                    directed_rows[i].want);

    // Random sequences; no idling near the end
    total = items_sent + RANDOM_ITEMS;
    while (items_sent < total) begin
      if (items_sent >= total - CALM_TAIL) calm = 1'b1;
      run_scenario(none);
    end
    in_tvalid <= 1'b0;

    // Drain outstanding results
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver stalls in random bursts, with stall-free stretches
  initial begin : ready_driver
    int   run;
    logic idle_on;
    idle_on = 1'b1;
    run     = $urandom_range(50, 300);
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!calm && idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_tready <= 1'b1;
      run--;
      if (run <= 0) begin
        idle_on = !idle_on;
        run     = $urandom_range(50, 300);
      end
    end
  end

  // Sample both channels, predict, check, and guard against a hang
  always @(posedge clk) begin : monitor
    res_t got, want, predicted;
    logic out_fire;
    if (!rst_n) begin
      in_taken    = 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken = in_tvalid && in_tready;
      out_fire = out_tvalid && out_tready;

      // Compare a result transaction with the oldest expected one
      if (out_fire) begin
        got.status    = status_t'(out_tdata[1:0]);
        got.trap_kind = trap_t'(out_tdata[3:2]);
        got.next_pc   = out_tdata[67:4];
        if (pending_results.size() == 0) begin
          $error("status: no result expected, actual %0d", got.status);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
          end
          if (got.trap_kind !== want.trap_kind) begin
            $error("trap_kind: expected %0d, actual %0d", want.trap_kind, got.trap_kind);
            errors++;
          end
          if (got.next_pc !== want.next_pc) begin
            $error("next_pc: expected %h, actual %h", want.next_pc, got.next_pc);
            errors++;
          end
        end
      end

      // Advance the executor on each accepted operation
      if (in_taken) begin
        predicted = execute_op(cur_op);
        pending_results.push_back(cur_fixed ? cur_want : predicted);
      end

      if (in_taken || out_fire) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

endmodule

`default_nettype wire
